// ===== rtl/bpa_pkg.sv =====
// Shared types, constants and helper functions for the buddy page allocator.
// No dependencies; every other file refers to it by scoped names.
package bpa_pkg;

    localparam int NUM_ORDERS = 11;
    localparam int ORD_W      = 4;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 16;
    localparam int ROW_BITS   = 32;
    localparam int ROWS       = 258;
    localparam int ROW_AW     = 9;
    localparam int ROFF_W     = 7;

    localparam logic [ORD_W-1:0] TOP_ORDER   = 4'd10;
    localparam logic [ORD_W-1:0] ORDER_LIMIT = 4'd11;
    localparam logic [CNT_W-1:0] MAX_PAGES   = 13'd4096;
    localparam logic [CNT_W-1:0] MAX_REQUEST = 13'd1024;
    localparam logic [CNT_W-1:0] FREE_SAT    = 13'd8191;

    // First bitmap row of each order; each row packs 32 block bits.
    localparam logic [ROW_AW-1:0] ROW_BASE [NUM_ORDERS] =
        '{9'd0, 9'd128, 9'd192, 9'd224, 9'd240, 9'd248,
          9'd252, 9'd254, 9'd255, 9'd256, 9'd257};

    typedef enum logic [1:0] {
        FUNC_INIT  = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_BLOCK = 2'd1,
        STAT_BAD_SIZE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CARVE,
        S_SCAN_ORD,
        S_SCAN_CHK,
        S_SPLIT,
        S_FREE_RD,
        S_FREE_CHK,
        S_MERGE,
        S_MERGE_CHK,
        S_BW_RD,
        S_BW_WR,
        S_SUM,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [ROW_AW-1:0]   addr;
        logic [ROW_BITS-1:0] wdata;
    } mem_req_t;

    function automatic logic [ROW_AW-1:0] row_addr(logic [ORD_W-1:0] order,
                                                   logic [IDX_W-1:0] idx);
        logic [ROW_AW-1:0] base;
        base = (order < ORDER_LIMIT) ? ROW_BASE[order] : '0;
        return base + ROW_AW'(idx >> 5);
    endfunction

    // Smallest order whose block holds n pages, for n from 1 to 1024.
    function automatic logic [ORD_W-1:0] order_of(logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        logic [ORD_W-1:0] o;
        m = n - 13'd1;
        o = '0;
        for (int i = 0; i < NUM_ORDERS; i++) begin
            if (m[i]) o = ORD_W'(i + 1);
        end
        return o;
    endfunction

    function automatic logic [4:0] lowest_bit(logic [ROW_BITS-1:0] w);
        logic [4:0] b;
        b = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (w[i]) b = 5'(i);
        end
        return b;
    endfunction

endpackage

// ===== rtl/bpa_bitmap.sv =====
// Free-block bitmap memory: 258 rows of 32 bits, one port, registered read.
// Depends on bpa_pkg for sizes and the request struct.
module bpa_bitmap (
    input  logic                          aclk,
    input  bpa_pkg::mem_req_t             req,
    output logic [bpa_pkg::ROW_BITS-1:0]  rd_data
);

    logic [bpa_pkg::ROW_BITS-1:0] mem [bpa_pkg::ROWS];
    logic [bpa_pkg::ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/buddy_page_allocator_core.sv =====
// Buddy page allocator: sequencer, per-order counters and the result register.
// Depends on bpa_pkg and instantiates bpa_bitmap.
//
// Usage: one command word enters on s_* (func, page_count, block_address) and
// one result word leaves on m_* (status, allocated address, free page total).
// The block takes one command at a time; s_ready is high only while idle.
// The pool size is to be written on cfg_* while the block is idle, which the
// block does not enforce; cfg_ready is always high and the next init uses it.
// Latency depends on the command. Every command ends with a sum over the
// per-order counters. Init first clears all 258 bitmap rows, one row a cycle,
// then sets up to 13 blocks, each by a bitmap read and write. Allocate reads
// one bitmap row a cycle in the smallest non-empty adequate order (up to 128
// rows for single pages) and does a read and a write per split; free does a
// buddy check and a read and write per merge level on the single-port memory.
// After reset the same clearing pass of all 258 rows runs before s_ready rises.
// A result waits in the output register while m_ready is low; the next
// command can already be accepted and processed, and its result is held
// back until the previous one is taken.
module buddy_page_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [12:0] s_page_count,
    input  logic [11:0] s_block_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [11:0] m_block_address_res,
    output logic [12:0] m_free_pages,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_total_pages
);

    bpa_pkg::state_t state_reg, state_next, ret_reg;
    bpa_pkg::mem_req_t mem_req;
    logic [bpa_pkg::ROW_BITS-1:0] rd_data;

    logic [bpa_pkg::CNT_W-1:0]  total_pages_reg;
    logic [bpa_pkg::CNT_W-1:0]  cnt_reg [bpa_pkg::NUM_ORDERS];
    logic [bpa_pkg::ORD_W-1:0]  req_reg, cur_order_reg, bw_order_reg, sum_k_reg;
    logic [bpa_pkg::IDX_W-1:0]  cur_idx_reg, bw_idx_reg;
    logic                       bw_val_reg, init_pend_reg;
    logic [bpa_pkg::CNT_W-1:0]  left_reg, carve_addr_reg;
    logic [bpa_pkg::ROW_AW-1:0] clr_row_reg;
    logic [bpa_pkg::ROFF_W-1:0] row_off_reg;
    logic [bpa_pkg::SUM_W-1:0]  sum_reg;
    logic [1:0]                 status_reg;
    logic [11:0]                addr_res_reg;
    logic                       m_valid_reg;
    logic [1:0]                 m_status_reg;
    logic [11:0]                m_addr_reg;
    logic [12:0]                m_free_reg;

    logic        bad_size, scan_hit, bw_bit, own_bit, buddy_bit, carve_fits, out_free;
    logic [4:0]  hit_bit;
    logic [bpa_pkg::CNT_W-1:0]  carve_size;
    logic [bpa_pkg::CNT_W-1:0]  cur_cnt;
    logic [bpa_pkg::ORD_W-1:0]  in_order;
    logic [bpa_pkg::IDX_W-1:0]  scan_idx, scan_next_idx;

    bpa_bitmap u_bitmap (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign s_ready   = (state_reg == bpa_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_block_address_res = m_addr_reg;
    assign m_free_pages        = m_free_reg;

    assign in_order   = bpa_pkg::order_of(s_page_count);
    assign bad_size   = (s_page_count == '0) || (s_page_count > bpa_pkg::MAX_REQUEST);
    assign scan_hit   = (rd_data != '0);
    assign hit_bit    = bpa_pkg::lowest_bit(rd_data);
    assign bw_bit     = rd_data[bw_idx_reg[4:0]];
    assign own_bit    = rd_data[cur_idx_reg[4:0]];
    assign buddy_bit  = rd_data[cur_idx_reg[4:0] ^ 5'd1];
    assign carve_size = bpa_pkg::CNT_W'(1) << cur_order_reg;
    assign carve_fits = (cur_order_reg == '0) || (left_reg >= carve_size);
    assign cur_cnt    = (cur_order_reg < bpa_pkg::ORDER_LIMIT) ? cnt_reg[cur_order_reg] : '0;
    assign scan_idx      = {row_off_reg, 5'd0};
    assign scan_next_idx = {row_off_reg + 7'd1, 5'd0};
    assign out_free   = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpa_pkg::S_CLEAR: begin
                if (clr_row_reg == bpa_pkg::ROW_AW'(bpa_pkg::ROWS - 1)) begin
                    state_next = init_pend_reg ? bpa_pkg::S_CARVE : bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        bpa_pkg::FUNC_INIT:  state_next = bpa_pkg::S_CLEAR;
                        bpa_pkg::FUNC_ALLOC: state_next = bad_size ? bpa_pkg::S_SUM
                                                                   : bpa_pkg::S_SCAN_ORD;
                        bpa_pkg::FUNC_FREE:  state_next = bad_size ? bpa_pkg::S_SUM
                                                                   : bpa_pkg::S_FREE_RD;
                        default:             state_next = bpa_pkg::S_SUM;
                    endcase
                end
            end
            bpa_pkg::S_CARVE: begin
                if (left_reg == '0) begin
                    state_next = bpa_pkg::S_SUM;
                end else if (carve_fits) begin
                    state_next = bpa_pkg::S_BW_RD;
                end
            end
            bpa_pkg::S_SCAN_ORD: begin
                if (cur_order_reg == bpa_pkg::ORDER_LIMIT) begin
                    state_next = bpa_pkg::S_SUM;
                end else if (cur_cnt != '0) begin
                    state_next = bpa_pkg::S_SCAN_CHK;
                end
            end
            bpa_pkg::S_SCAN_CHK: begin
                if (scan_hit) state_next = bpa_pkg::S_SPLIT;
            end
            bpa_pkg::S_SPLIT: begin
                state_next = (cur_order_reg > req_reg) ? bpa_pkg::S_BW_RD : bpa_pkg::S_SUM;
            end
            bpa_pkg::S_FREE_RD:  state_next = bpa_pkg::S_FREE_CHK;
            bpa_pkg::S_FREE_CHK: state_next = own_bit ? bpa_pkg::S_SUM : bpa_pkg::S_MERGE;
            bpa_pkg::S_MERGE: begin
                state_next = (cur_order_reg < bpa_pkg::TOP_ORDER) ? bpa_pkg::S_MERGE_CHK
                                                                  : bpa_pkg::S_BW_RD;
            end
            bpa_pkg::S_MERGE_CHK: state_next = bpa_pkg::S_BW_RD;
            bpa_pkg::S_BW_RD:     state_next = bpa_pkg::S_BW_WR;
            bpa_pkg::S_BW_WR:     state_next = ret_reg;
            bpa_pkg::S_SUM: begin
                if (sum_k_reg == bpa_pkg::TOP_ORDER) state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE: begin
                if (out_free) state_next = bpa_pkg::S_IDLE;
            end
            default: state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // Bitmap memory requests.
    always_comb begin
        mem_req = '0;
        case (state_reg)
            bpa_pkg::S_CLEAR: begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = clr_row_reg;
            end
            bpa_pkg::S_SCAN_ORD: begin
                mem_req.rd_en = (cur_order_reg < bpa_pkg::ORDER_LIMIT);
                mem_req.addr  = bpa_pkg::row_addr(cur_order_reg, scan_idx);
            end
            bpa_pkg::S_SCAN_CHK: begin
                if (scan_hit) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = bpa_pkg::row_addr(cur_order_reg, scan_idx);
                    mem_req.wdata = rd_data & ~(bpa_pkg::ROW_BITS'(1) << hit_bit);
                end else begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = bpa_pkg::row_addr(cur_order_reg, scan_next_idx);
                end
            end
            bpa_pkg::S_FREE_RD, bpa_pkg::S_MERGE: begin
                // The buddy always lives in the same row as the block itself.
                mem_req.rd_en = 1'b1;
                mem_req.addr  = bpa_pkg::row_addr(cur_order_reg, cur_idx_reg);
            end
            bpa_pkg::S_BW_RD: begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = bpa_pkg::row_addr(bw_order_reg, bw_idx_reg);
            end
            bpa_pkg::S_BW_WR: begin
                mem_req.wr_en = (bw_bit != bw_val_reg);
                mem_req.addr  = bpa_pkg::row_addr(bw_order_reg, bw_idx_reg);
                mem_req.wdata = rd_data;
                mem_req.wdata[bw_idx_reg[4:0]] = bw_val_reg;
            end
            default: mem_req = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bpa_pkg::S_CLEAR;
            ret_reg         <= bpa_pkg::S_IDLE;
            clr_row_reg     <= '0;
            init_pend_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            total_pages_reg <= bpa_pkg::MAX_PAGES;
            sum_k_reg       <= '0;
            for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) cnt_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) total_pages_reg <= cfg_total_pages;
            // A new result loads the output register from the done state instead.
            if (m_valid_reg && m_ready && state_reg != bpa_pkg::S_DONE) m_valid_reg <= 1'b0;

            case (state_reg)
                bpa_pkg::S_CLEAR: begin
                    clr_row_reg    <= clr_row_reg + 9'd1;
                    left_reg       <= (total_pages_reg > bpa_pkg::MAX_PAGES)
                                      ? bpa_pkg::MAX_PAGES : total_pages_reg;
                    carve_addr_reg <= '0;
                    cur_order_reg  <= bpa_pkg::TOP_ORDER;
                    if (clr_row_reg == bpa_pkg::ROW_AW'(bpa_pkg::ROWS - 1)) begin
                        init_pend_reg <= 1'b0;
                    end
                end
                bpa_pkg::S_IDLE: begin
                    sum_k_reg    <= '0;
                    sum_reg      <= '0;
                    row_off_reg  <= '0;
                    if (s_valid) begin
                        req_reg       <= in_order;
                        cur_order_reg <= in_order;
                        cur_idx_reg   <= bpa_pkg::IDX_W'(s_block_address >> in_order);
                        addr_res_reg  <= '0;
                        case (s_func)
                            bpa_pkg::FUNC_INIT: begin
                                status_reg    <= bpa_pkg::STAT_OK;
                                clr_row_reg   <= '0;
                                init_pend_reg <= 1'b1;
                                for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) cnt_reg[i] <= '0;
                            end
                            bpa_pkg::FUNC_ALLOC, bpa_pkg::FUNC_FREE: begin
                                status_reg <= bad_size ? bpa_pkg::STAT_BAD_SIZE
                                                       : bpa_pkg::STAT_OK;
                            end
                            default: status_reg <= bpa_pkg::STAT_BAD_SIZE;
                        endcase
                    end
                end
                bpa_pkg::S_CARVE: begin
                    if (left_reg != '0) begin
                        if (carve_fits) begin
                            bw_order_reg   <= cur_order_reg;
                            bw_idx_reg     <= bpa_pkg::IDX_W'(carve_addr_reg >> cur_order_reg);
                            bw_val_reg     <= 1'b1;
                            ret_reg        <= bpa_pkg::S_CARVE;
                            left_reg       <= left_reg - carve_size;
                            carve_addr_reg <= carve_addr_reg + carve_size;
                        end else begin
                            cur_order_reg <= cur_order_reg - 4'd1;
                        end
                    end
                end
                bpa_pkg::S_SCAN_ORD: begin
                    if (cur_order_reg == bpa_pkg::ORDER_LIMIT) begin
                        status_reg <= bpa_pkg::STAT_NO_BLOCK;
                    end else if (cur_cnt == '0) begin
                        cur_order_reg <= cur_order_reg + 4'd1;
                    end
                end
                bpa_pkg::S_SCAN_CHK: begin
                    if (scan_hit) begin
                        cur_idx_reg            <= {row_off_reg, hit_bit};
                        cnt_reg[cur_order_reg] <= cur_cnt - 13'd1;
                    end else begin
                        row_off_reg <= row_off_reg + 7'd1;
                    end
                end
                bpa_pkg::S_SPLIT: begin
                    if (cur_order_reg > req_reg) begin
                        // Keep the lower half and free the upper one.
                        cur_order_reg <= cur_order_reg - 4'd1;
                        cur_idx_reg   <= {cur_idx_reg[10:0], 1'b0};
                        bw_order_reg  <= cur_order_reg - 4'd1;
                        bw_idx_reg    <= {cur_idx_reg[10:0], 1'b1};
                        bw_val_reg    <= 1'b1;
                        ret_reg       <= bpa_pkg::S_SPLIT;
                    end else begin
                        addr_res_reg <= 12'(cur_idx_reg << req_reg);
                    end
                end
                bpa_pkg::S_MERGE: begin
                    if (cur_order_reg >= bpa_pkg::TOP_ORDER) begin
                        bw_order_reg <= cur_order_reg;
                        bw_idx_reg   <= cur_idx_reg;
                        bw_val_reg   <= 1'b1;
                        ret_reg      <= bpa_pkg::S_SUM;
                    end
                end
                bpa_pkg::S_MERGE_CHK: begin
                    if (buddy_bit) begin
                        bw_order_reg  <= cur_order_reg;
                        bw_idx_reg    <= cur_idx_reg ^ 12'd1;
                        bw_val_reg    <= 1'b0;
                        ret_reg       <= bpa_pkg::S_MERGE;
                        cur_idx_reg   <= cur_idx_reg >> 1;
                        cur_order_reg <= cur_order_reg + 4'd1;
                    end else begin
                        bw_order_reg <= cur_order_reg;
                        bw_idx_reg   <= cur_idx_reg;
                        bw_val_reg   <= 1'b1;
                        ret_reg      <= bpa_pkg::S_SUM;
                    end
                end
                bpa_pkg::S_BW_WR: begin
                    if (bw_bit != bw_val_reg) begin
                        cnt_reg[bw_order_reg] <= bw_val_reg ? cnt_reg[bw_order_reg] + 13'd1
                                                            : cnt_reg[bw_order_reg] - 13'd1;
                    end
                end
                bpa_pkg::S_SUM: begin
                    sum_reg   <= sum_reg + (bpa_pkg::SUM_W'(cnt_reg[sum_k_reg]) << sum_k_reg);
                    sum_k_reg <= sum_k_reg + 4'd1;
                end
                bpa_pkg::S_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_addr_reg   <= addr_res_reg;
                        m_free_reg   <= (sum_reg > bpa_pkg::SUM_W'(bpa_pkg::FREE_SAT))
                                        ? bpa_pkg::FREE_SAT : sum_reg[12:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // The block is busy right after it takes a command word.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted while still busy");

    // Reset always starts with the clearing pass.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during clearing pass");

    // Only successful allocations report an address.
    a_addr_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != bpa_pkg::STAT_OK |-> m_block_address_res == '0)
        else $error("address reported for failed request");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= bpa_pkg::STAT_BAD_SIZE)
        else $error("undefined status code");

endmodule

// ===== dv/bpa_checker.sv =====
`timescale 1ns / 100ps
// Checker for the buddy page allocator: watches the command, result and pool size
// channels, predicts every result word and compares it. Depends on bpa_pkg.
module bpa_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [12:0] s_page_count,
    input  logic [11:0] s_block_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [11:0] m_block_address_res,
    input  logic [12:0] m_free_pages,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [12:0] cfg_total_pages,
    output int          err_count,
    output int          results_owed
);

    typedef struct packed {
        bpa_pkg::status_t status;
        logic [11:0]      addr;
        logic [12:0]      free_total;
    } result_t;

    localparam int POOL = 4096;

    logic        free_map [bpa_pkg::NUM_ORDERS][POOL];
    int          order_free [bpa_pkg::NUM_ORDERS];
    logic [12:0] pool_pages;
    result_t     owed_q[$];

    task automatic mark(int o, int idx, logic v);
        if (idx >= (POOL >> o)) return;
        if (free_map[o][idx] == v) return;
        free_map[o][idx] = v;
        if (v) order_free[o]++;
        else order_free[o]--;
    endtask

    task automatic wipe_pool();
        for (int o = 0; o < bpa_pkg::NUM_ORDERS; o++) begin
            order_free[o] = 0;
            for (int i = 0; i < POOL; i++) free_map[o][i] = 1'b0;
        end
    endtask

    function automatic int size_order(int n);
        int o;
        o = 0;
        while ((1 << o) < n) o++;
        return o;
    endfunction

    task automatic carve_pool();
        int left, o, a;
        wipe_pool();
        left = (pool_pages > POOL) ? POOL : int'(pool_pages);
        o = bpa_pkg::NUM_ORDERS - 1;
        a = 0;
        while (left != 0) begin
            while (o > 0 && left < (1 << o)) o--;
            mark(o, a >> o, 1'b1);
            left -= 1 << o;
            a += 1 << o;
        end
    endtask

    task automatic take_block(int n, output bpa_pkg::status_t st, output logic [11:0] addr);
        int req, o, idx;
        bit found;
        found = 0;
        addr = '0;
        st = bpa_pkg::STAT_NO_BLOCK;
        req = size_order(n);
        for (int ord = req; ord < bpa_pkg::NUM_ORDERS && !found; ord++) begin
            for (int i = 0; i < (POOL >> ord) && !found; i++) begin
                if (free_map[ord][i]) begin
                    found = 1;
                    o = ord;
                    idx = i;
                end
            end
        end
        if (found) begin
            mark(o, idx, 1'b0);
            // Keep the lower half at each split and hand back the upper one.
            while (o > req) begin
                o--;
                idx = idx << 1;
                mark(o, idx + 1, 1'b1);
            end
            addr = 12'(idx << req);
            st = bpa_pkg::STAT_OK;
        end
    endtask

    task automatic give_back(int n, int a, output bpa_pkg::status_t st);
        int o, idx;
        o = size_order(n);
        idx = a >> o;
        st = bpa_pkg::STAT_OK;
        if (idx >= (POOL >> o)) begin
            st = bpa_pkg::STAT_BAD_SIZE;
        end else if (!free_map[o][idx]) begin
            while (o + 1 < bpa_pkg::NUM_ORDERS && (idx ^ 1) < (POOL >> o) &&
                   free_map[o][idx ^ 1]) begin
                mark(o, idx ^ 1, 1'b0);
                idx = idx >> 1;
                o++;
            end
            mark(o, idx, 1'b1);
        end
    endtask

    task automatic predict_word(logic [1:0] f, logic [12:0] n, logic [11:0] a);
        result_t r;
        int sum;
        r.status = bpa_pkg::STAT_OK;
        r.addr = '0;
        case (bpa_pkg::func_t'(f))
            bpa_pkg::FUNC_INIT: carve_pool();
            bpa_pkg::FUNC_ALLOC: begin
                if (n == 0 || n > bpa_pkg::MAX_REQUEST) r.status = bpa_pkg::STAT_BAD_SIZE;
                else take_block(int'(n), r.status, r.addr);
            end
            bpa_pkg::FUNC_FREE: begin
                if (n == 0 || n > bpa_pkg::MAX_REQUEST) r.status = bpa_pkg::STAT_BAD_SIZE;
                else give_back(int'(n), int'(a), r.status);
            end
            default: r.status = bpa_pkg::STAT_BAD_SIZE;
        endcase
        sum = 0;
        for (int o = 0; o < bpa_pkg::NUM_ORDERS; o++) begin
            sum += order_free[o] << o;
            if (sum > 8191) sum = 8191;
        end
        r.free_total = 13'(sum);
        owed_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            wipe_pool();
            pool_pages = bpa_pkg::MAX_PAGES;
            owed_q.delete();
            err_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) pool_pages = cfg_total_pages;
            if (s_valid && s_ready) predict_word(s_func, s_page_count, s_block_address);
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result word with nothing expected: %0d %0d %0d",
                                 $realtime, m_status, m_block_address_res, m_free_pages);
                end else begin
                    exp_r = owed_q.pop_front();
                    if (m_status !== exp_r.status || m_block_address_res !== exp_r.addr ||
                        m_free_pages !== exp_r.free_total) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: status/addr/free exp %0d %0d %0d got %0d %0d %0d",
                                     $realtime, exp_r.status, exp_r.addr, exp_r.free_total,
                                     m_status, m_block_address_res, m_free_pages);
                    end
                end
            end
        end
        results_owed = owed_q.size();
    end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top of the buddy page allocator testbench: clock, reset, command stimulus,
// result-side back pressure and the verdict. Depends on bpa_pkg, bpa_checker and the core.
module tb;

    logic        aclk;
    logic        aresetn;
    logic        s_valid, s_ready;
    logic [1:0]  s_func;
    logic [12:0] s_page_count;
    logic [11:0] s_block_address;
    logic        m_valid, m_ready;
    logic [1:0]  m_status;
    logic [11:0] m_block_address_res;
    logic [12:0] m_free_pages;
    logic        cfg_valid, cfg_ready;
    logic [12:0] cfg_total_pages;
    int          err_count, results_owed;
    int          send_idle, recv_idle, stall_cycles;
    logic        stall_req, stall_used;
    int          quiet_cycles;

    typedef struct packed {
        logic [1:0]  f;
        logic [12:0] n;
    } sent_t;
    typedef struct packed {
        logic [11:0] a;
        logic [12:0] n;
    } live_t;
    sent_t sent_q[$];
    live_t held_blocks[$];

    buddy_page_allocator_core i_dut (.*);
    bpa_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Follow results so that frees can return blocks that really were handed out.
    always @(posedge aclk) begin
        sent_t c;
        if (aresetn && m_valid && m_ready && sent_q.size() != 0) begin
            c = sent_q.pop_front();
            if (bpa_pkg::func_t'(c.f) == bpa_pkg::FUNC_ALLOC &&
                bpa_pkg::status_t'(m_status) == bpa_pkg::STAT_OK)
                held_blocks.push_back('{m_block_address_res, c.n});
        end
    end

    always @(negedge aclk) begin
        if (stall_req && !stall_used) begin
            stall_used <= 1'b1;
            stall_cycles <= 400;
            m_ready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 6000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(bpa_pkg::func_t f, logic [12:0] n, logic [11:0] a);
        while ($urandom_range(0, 99) < send_idle) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_func <= f;
        s_page_count <= n;
        s_block_address <= a;
        sent_q.push_back('{f, n});
        if (f == bpa_pkg::FUNC_INIT) held_blocks.delete();
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic set_pool(logic [12:0] pages);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_total_pages <= pages;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word();
        live_t b;
        int k, lo;
        if ($urandom_range(0, 99) < 18) begin
            send_word(bpa_pkg::func_t'($urandom_range(0, 3)), 13'($urandom), 12'($urandom));
        end else if (held_blocks.size() != 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, held_blocks.size() - 1);
            b = held_blocks[k];
            held_blocks.delete(k);
            lo = (b.n <= 1) ? 1 : (b.n / 2 + 1);
            // Sometimes free with a misaligned address inside the block.
            send_word(bpa_pkg::FUNC_FREE, 13'($urandom_range(lo, b.n)),
                      $urandom_range(0, 3) == 0 ? b.a | 12'($urandom_range(0, b.n - 1)) : b.a);
        end else begin
            send_word(bpa_pkg::FUNC_ALLOC,
                      $urandom_range(0, 9) == 0 ? 13'($urandom_range(1, 1024))
                                                : 13'($urandom_range(1, 16)), '0);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = '0;
        s_page_count = '0;
        s_block_address = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_total_pages = '0;
        send_idle = 0;
        recv_idle = 0;
        stall_cycles = 0;
        stall_req = 1'b0;
        stall_used = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part with the default pool size of 4096 pages.
        send_word(bpa_pkg::FUNC_INIT, '0, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd1, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd1024, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd3, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd0, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd1025, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd8191, 12'hFFF);
        send_word(bpa_pkg::FUNC_FREE, 13'd0, '0);
        send_word(bpa_pkg::FUNC_FREE, 13'd4096, '0);
        send_word(bpa_pkg::FUNC_FREE, 13'd4, 12'd7);
        send_word(bpa_pkg::FUNC_FREE, 13'd4, 12'd4);
        send_word(bpa_pkg::FUNC_FREE, 13'd1024, 12'hFFF);
        send_word(bpa_pkg::FUNC_FREE, 13'd1, '0);
        send_word(bpa_pkg::FUNC_NONE, 13'h1FFF, 12'hFFF);
        repeat (5) send_word(bpa_pkg::FUNC_ALLOC, 13'd1024, '0);
        drain();
        set_pool(13'd0);
        send_word(bpa_pkg::FUNC_INIT, '0, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd1, '0);
        drain();
        set_pool(13'h1FFF);
        send_word(bpa_pkg::FUNC_INIT, '0, '0);
        drain();
        set_pool(13'd1);
        send_word(bpa_pkg::FUNC_INIT, '0, '0);
        send_word(bpa_pkg::FUNC_ALLOC, 13'd2, '0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 26 : (phase == 1) ? 75 : 0;
            recv_idle = (phase == 0) ? 75 : (phase == 1) ? 26 : 0;
            set_pool(phase == 0 ? 13'd4096 : 13'($urandom_range(1, 4095)));
            send_word(bpa_pkg::FUNC_INIT, '0, '0);
            for (int i = 0; i < 290; i++) begin
                if (phase == 2 && i == 20) stall_req <= 1'b1;
                random_word();
            end
            drain();
        end

        if (results_owed == 0 && err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
